// File: hw/rtl/twls_pkg.sv
// Shared types and constants for the trilinear window-level sampler.
// No dependencies; imported by the top level and its port checker.
`default_nettype none

package twls_pkg;

  // Fraction bits kept through the lerp chain (corners enter as Q8.FRAC_BITS).
  localparam int FRAC_BITS = 8;
  localparam int Q_W       = 8 + FRAC_BITS;

  // Register index width on the config port.
  localparam int CFG_IDX_W = 2;

  // Cycles from an accepted start to its out_strobe.
  localparam int PIPE_LAT = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOW  = 2'd0,
    REG_WINDOW_HIGH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] corner_000;
    logic [7:0] corner_001;
    logic [7:0] corner_010;
    logic [7:0] corner_011;
    logic [7:0] corner_100;
    logic [7:0] corner_101;
    logic [7:0] corner_110;
    logic [7:0] corner_111;
    logic [7:0] frac_x;
    logic [7:0] frac_y;
    logic [7:0] frac_z;
    logic       nearest_mode;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_argb;
    logic [7:0]  grey_level;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/trilinear_window_level_sampler_top.sv
// Trilinear / nearest voxel sampler with window-level grey mapping, top level.
// Depends on twls_pkg (item structs, FRAC_BITS, register codes).
//
//   channel | ports                              | handshake
//   --------+------------------------------------+-----------------------------
//   input   | start, busy, in_data               | beat taken when start & !busy
//   result  | out_strobe, out_data               | one-cycle strobe, no stall
//   config  | cfg_we, cfg_idx, cfg_wdata         | write on cfg_we, no wait
//
// One beat per cycle out of reset, through x, y and z lerp stages, a window
// prep stage, a four-stage restoring divider (two quotient bits per stage)
// and the output register. busy is high only while rst_n is low.
// Reset clears the valid bits and loads window_low = 0, window_high = 255.
// Nothing stalls: results leave on the strobe whether or not anyone looks.
`default_nettype none

module trilinear_window_level_sampler_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire twls_pkg::in_item_t in_data,
  output logic                    out_strobe,
  output twls_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [twls_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [7:0]         cfg_wdata
);
  import twls_pkg::*;

  localparam int DIV_STAGES = 4;

  function automatic logic [Q_W-1:0] lerp_q(input logic [Q_W-1:0] a,
                                            input logic [Q_W-1:0] b,
                                            input logic [7:0]     f);
    logic [8:0]      wf;
    logic [Q_W+9:0]  acc;
    wf  = 9'd256 - {1'b0, f};
    acc = ({10'd0, a} * (Q_W+10)'(wf)) + ({10'd0, b} * (Q_W+10)'(f));
    return acc[Q_W+7:8];
  endfunction

  function automatic logic [Q_W-1:0] to_q(input logic [7:0] c);
    return Q_W'(c) << FRAC_BITS;
  endfunction

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // ---------------- config registers
  logic [7:0] win_lo_r;
  logic [7:0] win_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_lo_r <= 8'd0;
      win_hi_r <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_WINDOW_LOW:  win_lo_r <= cfg_wdata;
        REG_WINDOW_HIGH: win_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: x lerps, nearest pick
  logic           s1_vld_r;
  logic [Q_W-1:0] s1_y0_r, s1_y1_r, s1_z0_r, s1_z1_r;
  logic [7:0]     s1_fy_r, s1_fz_r, s1_near_r;
  logic           s1_mode_r;
  logic [7:0]     near_nxt;
  logic [2:0]     near_sel;

  assign near_sel = {in_data.frac_z[7], in_data.frac_y[7], in_data.frac_x[7]};

  always_comb begin
    case (near_sel)
      3'd0:    near_nxt = in_data.corner_000;
      3'd1:    near_nxt = in_data.corner_001;
      3'd2:    near_nxt = in_data.corner_010;
      3'd3:    near_nxt = in_data.corner_011;
      3'd4:    near_nxt = in_data.corner_100;
      3'd5:    near_nxt = in_data.corner_101;
      3'd6:    near_nxt = in_data.corner_110;
      default: near_nxt = in_data.corner_111;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    s1_y0_r   <= lerp_q(to_q(in_data.corner_000), to_q(in_data.corner_001), in_data.frac_x);
    s1_y1_r   <= lerp_q(to_q(in_data.corner_010), to_q(in_data.corner_011), in_data.frac_x);
    s1_z0_r   <= lerp_q(to_q(in_data.corner_100), to_q(in_data.corner_101), in_data.frac_x);
    s1_z1_r   <= lerp_q(to_q(in_data.corner_110), to_q(in_data.corner_111), in_data.frac_x);
    s1_fy_r   <= in_data.frac_y;
    s1_fz_r   <= in_data.frac_z;
    s1_near_r <= near_nxt;
    s1_mode_r <= in_data.nearest_mode;
  end

  // ---------------- stage 2: y lerps
  logic           s2_vld_r;
  logic [Q_W-1:0] s2_y_r, s2_z_r;
  logic [7:0]     s2_fz_r, s2_near_r;
  logic           s2_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_y_r    <= lerp_q(s1_y0_r, s1_y1_r, s1_fy_r);
    s2_z_r    <= lerp_q(s1_z0_r, s1_z1_r, s1_fy_r);
    s2_fz_r   <= s1_fz_r;
    s2_near_r <= s1_near_r;
    s2_mode_r <= s1_mode_r;
  end

  // ---------------- stage 3: z lerp, truncate, mode select
  logic           s3_vld_r;
  logic [7:0]     s3_v_r;
  logic [Q_W-1:0] zlerp_nxt;

  assign zlerp_nxt = lerp_q(s2_y_r, s2_z_r, s2_fz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    s3_v_r <= s2_mode_r ? s2_near_r : zlerp_nxt[Q_W-1:FRAC_BITS];
  end

  // ---------------- stage 4: window prep
  // span = max(hi, lo+1) - lo; numerator n = (v-lo)*255; sat when n/span >= 256
  logic        s4_vld_r;
  logic [15:0] s4_num_r;
  logic [7:0]  s4_span_r;
  logic        s4_zero_r, s4_sat_r;
  logic [8:0]  hi_min, hi_eff, span9;
  logic [7:0]  span_nxt, diff_nxt;
  logic [15:0] num_nxt;

  always_comb begin
    hi_min   = {1'b0, win_lo_r} + 9'd1;
    hi_eff   = ({1'b0, win_hi_r} < hi_min) ? hi_min : {1'b0, win_hi_r};
    span9    = hi_eff - {1'b0, win_lo_r};
    span_nxt = span9[7:0];
    diff_nxt = s3_v_r - win_lo_r;
    num_nxt  = {diff_nxt, 8'd0} - {8'd0, diff_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    s4_num_r  <= num_nxt;
    s4_span_r <= span_nxt;
    s4_zero_r <= (s3_v_r <= win_lo_r);
    s4_sat_r  <= (num_nxt >= {span_nxt, 8'd0});
  end

  // ---------------- stages 5..8: restoring divider, two bits per stage
  logic        div_vld_r  [DIV_STAGES];
  logic [15:0] div_rem_r  [DIV_STAGES];
  logic [7:0]  div_q_r    [DIV_STAGES];
  logic [7:0]  div_span_r [DIV_STAGES];
  logic        div_zero_r [DIV_STAGES];
  logic        div_sat_r  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic        vld_in, zero_in, sat_in;
    logic [15:0] rem_in, rem_nxt;
    logic [7:0]  q_in, q_nxt, span_in;

    if (k == 0) begin : g_head
      assign vld_in  = s4_vld_r;
      assign rem_in  = s4_num_r;
      assign q_in    = 8'd0;
      assign span_in = s4_span_r;
      assign zero_in = s4_zero_r;
      assign sat_in  = s4_sat_r;
    end else begin : g_body
      assign vld_in  = div_vld_r[k-1];
      assign rem_in  = div_rem_r[k-1];
      assign q_in    = div_q_r[k-1];
      assign span_in = div_span_r[k-1];
      assign zero_in = div_zero_r[k-1];
      assign sat_in  = div_sat_r[k-1];
    end

    always_comb begin
      logic [15:0] t;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int j = 0; j < 2; j++) begin
        t = {8'd0, span_in} << (7 - 2*k - j);
        if (rem_nxt >= t) begin
          rem_nxt = rem_nxt - t;
          q_nxt[7 - 2*k - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) div_vld_r[k] <= 1'b0;
      else        div_vld_r[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      div_rem_r[k]  <= rem_nxt;
      div_q_r[k]    <= q_nxt;
      div_span_r[k] <= span_in;
      div_zero_r[k] <= zero_in;
      div_sat_r[k]  <= sat_in;
    end
  end

  // ---------------- output register
  logic      out_vld_r;
  out_item_t out_data_r;
  logic [7:0] grey_nxt;

  always_comb begin
    if (div_zero_r[DIV_STAGES-1])     grey_nxt = 8'd0;
    else if (div_sat_r[DIV_STAGES-1]) grey_nxt = 8'd255;
    else                              grey_nxt = div_q_r[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= div_vld_r[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    out_data_r.pixel_argb <= {8'hFF, grey_nxt, grey_nxt, grey_nxt};
    out_data_r.grey_level <= grey_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/twls_checker.sv
// Port-level checker for the sampler top, bound in below.
// Depends on twls_pkg (item structs, PIPE_LAT).
`default_nettype none

module twls_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire twls_pkg::out_item_t out_data
);
  import twls_pkg::*;

  // cycles since reset release, saturating at the pipeline latency
  logic [3:0] quiet_cnt_r;
  logic       quiet;

  always_ff @(posedge clk) begin
    if (!rst_n) quiet_cnt_r <= 4'd0;
    else if (quiet_cnt_r < 4'(PIPE_LAT)) quiet_cnt_r <= quiet_cnt_r + 4'd1;
  end

  assign quiet = (quiet_cnt_r == 4'(PIPE_LAT));

  // every accepted beat comes out after the fixed latency
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    quiet && $past(start && !busy, PIPE_LAT) |-> out_strobe)
    else $error("accepted beat did not come out");

  // no result without a beat accepted that long ago
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching input beat");

  // pixel word is opaque and carries the grey byte in all three colors
  a_argb: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.pixel_argb[31:24] == 8'hFF) &&
                   (out_data.pixel_argb[23:16] == out_data.grey_level) &&
                   (out_data.pixel_argb[15:8]  == out_data.grey_level) &&
                   (out_data.pixel_argb[7:0]   == out_data.grey_level))
    else $error("pixel word does not match grey level");

  // not busy once out of reset
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> !busy)
    else $error("busy outside reset");

endmodule

bind trilinear_window_level_sampler_top twls_checker u_twls_checker (.*);

`default_nettype wire
